[hdl/wprs_pkg.sv]
package wprs_pkg;

	// Field widths.
	localparam int ARR_W   = 63;
	localparam int BYTES_W = 16;
	localparam int WIN_W   = 16;
	localparam int BT_W    = 24;
	localparam int CNT_W   = 32;
	localparam int BSUM_W  = 48;
	localparam int RATE_W  = 40;
	localparam int RSUM_W  = 63;
	localparam int SER_W   = 24;
	localparam int TIME_W  = 64;
	localparam int WINPS_W = 46;
	localparam int PROD_W  = 40;

	// Serial divider geometry, shared by both divisions.
	localparam int DVD_W     = 44;
	localparam int DVS_W     = 64;
	localparam int DIV_STEPS = 44;

	// Unit conversions.
	localparam logic [DVD_W-1:0] RATE_CEIL = 44'd1000000000000;
	localparam logic [DVS_W-1:0] FS_PER_NS_X8 = 64'd1000000;
	localparam logic [9:0]       PS_PER_NS = 10'd1000;
	localparam logic [29:0]      PS_PER_MS = 30'd1000000000;

	// Reset values of the window extremes.
	localparam logic [TIME_W-1:0] GAP_MIN_INIT = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [TIME_W-1:0] GAP_MAX_INIT = 64'h8000_0000_0000_0000;

	typedef enum logic [0:0] {
		CFG_WIN_LEN     = 1'b0,
		CFG_BIT_TIME_FS = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SER,
		ST_END,
		ST_GAP,
		ST_RATE,
		ST_UPD
	} state_t;

	typedef struct packed {
		logic [ARR_W-1:0]   arrival_ps;
		logic [BYTES_W-1:0] packet_bytes;
	} pkt_t;

	typedef struct packed {
		logic [ARR_W-1:0]   close_time_ps;
		logic [ARR_W-1:0]   window_length_ps;
		logic [CNT_W-1:0]   pkt_tally;
		logic [TIME_W-1:0]  min_gap_ps;
		logic [TIME_W-1:0]  max_gap_ps;
		logic [TIME_W-1:0]  gap_sum_ps;
		logic [BYTES_W-1:0] min_size;
		logic [BYTES_W-1:0] max_size;
		logic [BSUM_W-1:0]  byte_sum;
		logic [RATE_W-1:0]  min_rate_pps;
		logic [RATE_W-1:0]  max_rate_pps;
		logic [RSUM_W-1:0]  rate_sum_pps;
	} stats_t;

endpackage

[hdl/wprs_stream_if.sv]
interface wprs_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[hdl/wprs_sdiv.sv]
module wprs_sdiv (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [wprs_pkg::DVD_W-1:0] dividend,
	input  logic [wprs_pkg::DVS_W-1:0] divisor,
	output logic                       done,
	output logic [wprs_pkg::DVD_W-1:0] quotient
);
	import wprs_pkg::*;

	localparam int STEP_W = $clog2(DIV_STEPS + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [DVD_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DVD_W:0]    trial;
	logic [DVD_W:0]    diff;
	logic              fits;

	// One quotient bit per cycle: shift in the next dividend bit and try a subtract.
	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign fits  = {{(DVS_W-DVD_W-1){1'b0}}, trial} >= dvs_q;
	assign diff  = trial - dvs_q[DVD_W:0];

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && (step_q == STEP_W'(DIV_STEPS - 1));
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// The dividend register collects the quotient bits as it shifts out.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DVD_W-1:0] : trial[DVD_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n) start |-> !busy_q)
		else $error("divider started while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && !busy_q)
		else $error("divider done without a finished run");
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> ({{(DVS_W-DVD_W){1'b0}}, rem_q} < dvs_q))
		else $error("partial remainder not below divisor");
endmodule

[hdl/windowed_packet_rate_stats.sv]
// Channel   Dir  Beat contents
// in_ch     in   arrival_ps (63), packet_bytes (16)
// out_ch    out  one beat of window statistics when a window closes
// cfg_*     in   window length in ms (index 0), bit time in fs (index 1)
//
// One packet is in work at a time. From its beat to the next ready, a packet
// passes through the bit-serial length times bit time product, the serial divide
// down to nanoseconds, the end time and gap steps, the serial rate divide and the update.
// The first packet skips the rate divide and the update; one whose gap is
// not positive skips the rate divide.
// Reset loads the default configuration and an empty window; nothing is swept.
// A closing packet waits in its last step while a previous result is not yet taken.
module windowed_packet_rate_stats (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  wprs_pkg::cfg_idx_t          cfg_index,
	input  logic [wprs_pkg::BT_W-1:0]   cfg_wdata,
	wprs_stream_if.sink                 in_ch,
	wprs_stream_if.source               out_ch
);
	import wprs_pkg::*;

	state_t state_q, state_d;

	logic [WIN_W-1:0]   win_ms_q;
	logic [BT_W-1:0]    bt_q;
	logic [ARR_W-1:0]   arr_q;
	logic [BYTES_W-1:0] bytes_q;
	logic [BYTES_W-1:0] bytes_sh_q;
	logic [PROD_W-1:0]  mcand_q;
	logic [PROD_W-1:0]  acc_q;
	logic [PROD_W-1:0]  acc_nxt;
	logic [3:0]         mcnt_q;
	logic [SER_W-1:0]   ser_ns_q;
	logic [TIME_W-1:0]  cur_end_q;
	logic [WINPS_W-1:0] win_ps_q;

	logic               seen_q;
	logic [ARR_W-1:0]   start_q;
	logic [TIME_W-1:0]  prev_end_q;
	logic [CNT_W-1:0]   items_q;
	logic [CNT_W-1:0]   items_inc;

	logic [TIME_W-1:0]  gap_q;
	logic [TIME_W-1:0]  gap_c;
	logic [TIME_W:0]    gdiff;
	logic               gap_pos;
	logic               close_q;
	logic               close_c;
	logic [ARR_W-1:0]   elapsed;
	logic [ARR_W-1:0]   len_q;
	logic [RATE_W-1:0]  rate_q;

	logic [CNT_W-1:0]   cnt_q;
	logic [TIME_W-1:0]  gsum_q, gmin_q, gmax_q;
	logic [BSUM_W-1:0]  bsum_q;
	logic [RSUM_W-1:0]  rsum_q;
	logic [BYTES_W-1:0] smin_q, smax_q;
	logic [RATE_W-1:0]  rmin_q, rmax_q;

	logic [CNT_W-1:0]   cnt_b;
	logic [TIME_W-1:0]  gsum_b, gmin_b, gmax_b;
	logic [BSUM_W-1:0]  bsum_b;
	logic [RSUM_W-1:0]  rsum_b;
	logic [BYTES_W-1:0] smin_b, smax_b;
	logic [RATE_W-1:0]  rmin_b, rmax_b;
	logic [TIME_W:0]    gsum_w;
	logic [BSUM_W:0]    bsum_w;
	logic [RSUM_W:0]    rsum_w;

	logic               out_valid_q;
	stats_t             out_q;

	logic               accept;
	logic               upd_go;
	logic               div_start;
	logic [DVD_W-1:0]   div_dvd;
	logic [DVS_W-1:0]   div_dvs;
	logic               div_done;
	logic [DVD_W-1:0]   div_quot;

	assign accept = in_ch.valid && in_ch.ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_ms_q <= WIN_W'(100);
			bt_q     <= BT_W'(100000);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WIN_LEN:     win_ms_q <= cfg_wdata[WIN_W-1:0];
				CFG_BIT_TIME_FS: bt_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Bit-serial multiply of length by bit time, one length bit per cycle.
	assign acc_nxt = acc_q + (bytes_sh_q[0] ? mcand_q : '0);

	// Signed difference of end times, clamped to 64 bits.
	always_comb begin
		gdiff = {1'b0, cur_end_q} - {1'b0, prev_end_q};
		if (gdiff[TIME_W] != gdiff[TIME_W-1]) begin
			gap_c = gdiff[TIME_W] ? GAP_MAX_INIT : GAP_MIN_INIT;
		end else begin
			gap_c = gdiff[TIME_W-1:0];
		end
		gap_pos = !gap_c[TIME_W-1] && (gap_c != '0);
	end

	// Window close test.
	always_comb begin
		items_inc = (items_q == '1) ? items_q : items_q + 1'b1;
		elapsed   = arr_q - start_q;
		close_c   = (arr_q >= start_q) &&
			(elapsed > {{(ARR_W-WINPS_W){1'b0}}, win_ps_q}) &&
			(items_inc >= CNT_W'(2));
	end

	// Window base: a closing packet starts from an empty window.
	always_comb begin
		if (close_q) begin
			cnt_b  = '0;
			gsum_b = '0;
			bsum_b = '0;
			rsum_b = '0;
			gmin_b = GAP_MIN_INIT;
			gmax_b = GAP_MAX_INIT;
			smin_b = '1;
			smax_b = '0;
			rmin_b = '1;
			rmax_b = '0;
		end else begin
			cnt_b  = cnt_q;
			gsum_b = gsum_q;
			bsum_b = bsum_q;
			rsum_b = rsum_q;
			gmin_b = gmin_q;
			gmax_b = gmax_q;
			smin_b = smin_q;
			smax_b = smax_q;
			rmin_b = rmin_q;
			rmax_b = rmax_q;
		end
		gsum_w = {gsum_b[TIME_W-1], gsum_b} + {gap_q[TIME_W-1], gap_q};
		bsum_w = {1'b0, bsum_b} + {{(BSUM_W-BYTES_W+1){1'b0}}, bytes_q};
		rsum_w = {1'b0, rsum_b} + {{(RSUM_W-RATE_W+1){1'b0}}, rate_q};
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept) state_d = ST_MUL;
			ST_MUL:  if (mcnt_q == 4'd15) state_d = ST_SER;
			ST_SER:  if (div_done) state_d = ST_END;
			ST_END:  state_d = ST_GAP;
			ST_GAP: begin
				if (!seen_q) state_d = ST_IDLE;
				else if (gap_pos) state_d = ST_RATE;
				else state_d = ST_UPD;
			end
			ST_RATE: if (div_done) state_d = ST_UPD;
			ST_UPD:  if (upd_go) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		in_ch.ready = 1'b0;
		div_start   = 1'b0;
		upd_go      = 1'b0;
		div_dvd     = RATE_CEIL;
		div_dvs     = gap_c;
		case (state_q)
			ST_IDLE: in_ch.ready = 1'b1;
			ST_MUL: begin
				div_start = (mcnt_q == 4'd15);
				div_dvd   = {1'b0, acc_nxt, 3'b000};
				div_dvs   = FS_PER_NS_X8;
			end
			ST_GAP: div_start = seen_q && gap_pos;
			ST_UPD: upd_go = !(close_q && out_valid_q && !out_ch.ready);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	wprs_sdiv u_sdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Per-packet working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcnt_q <= '0;
		end else if (accept) begin
			mcnt_q <= '0;
		end else if (state_q == ST_MUL) begin
			mcnt_q <= mcnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			arr_q      <= in_ch.payload.arrival_ps;
			bytes_q    <= in_ch.payload.packet_bytes;
			bytes_sh_q <= in_ch.payload.packet_bytes;
			mcand_q    <= {{(PROD_W-BT_W){1'b0}}, bt_q};
			acc_q      <= '0;
		end else if (state_q == ST_MUL) begin
			acc_q      <= acc_nxt;
			bytes_sh_q <= bytes_sh_q >> 1;
			mcand_q    <= mcand_q << 1;
			win_ps_q   <= {{(WINPS_W-WIN_W){1'b0}}, win_ms_q} *
				{{(WINPS_W-30){1'b0}}, PS_PER_MS};
		end
		if (state_q == ST_SER && div_done) begin
			ser_ns_q <= div_quot[SER_W-1:0];
		end
		if (state_q == ST_END) begin
			cur_end_q <= {1'b0, arr_q} +
				({{(TIME_W-SER_W){1'b0}}, ser_ns_q} * {{(TIME_W-10){1'b0}}, PS_PER_NS});
		end
		if (state_q == ST_GAP) begin
			gap_q   <= gap_c;
			close_q <= close_c;
			len_q   <= elapsed;
			rate_q  <= RATE_CEIL[RATE_W-1:0];
		end
		if (state_q == ST_RATE && div_done) begin
			rate_q <= div_quot[RATE_W-1:0];
		end
	end

	// Trace and window state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= 1'b0;
			start_q    <= '0;
			prev_end_q <= '0;
			items_q    <= '0;
			cnt_q      <= '0;
			gsum_q     <= '0;
			bsum_q     <= '0;
			rsum_q     <= '0;
			gmin_q     <= GAP_MIN_INIT;
			gmax_q     <= GAP_MAX_INIT;
			smin_q     <= '1;
			smax_q     <= '0;
			rmin_q     <= '1;
			rmax_q     <= '0;
		end else if (state_q == ST_GAP && !seen_q) begin
			seen_q     <= 1'b1;
			start_q    <= arr_q;
			prev_end_q <= cur_end_q;
			items_q    <= '0;
		end else if (state_q == ST_GAP) begin
			items_q <= close_c ? '0 : items_inc;
			if (close_c) begin
				start_q <= arr_q;
			end
		end else if (upd_go) begin
			prev_end_q <= cur_end_q;
			cnt_q  <= (cnt_b == '1) ? cnt_b : cnt_b + 1'b1;
			if (gsum_w[TIME_W] != gsum_w[TIME_W-1]) begin
				gsum_q <= gsum_w[TIME_W] ? GAP_MAX_INIT : GAP_MIN_INIT;
			end else begin
				gsum_q <= gsum_w[TIME_W-1:0];
			end
			bsum_q <= bsum_w[BSUM_W] ? '1 : bsum_w[BSUM_W-1:0];
			rsum_q <= rsum_w[RSUM_W] ? '1 : rsum_w[RSUM_W-1:0];
			gmin_q <= ($signed(gap_q) < $signed(gmin_b)) ? gap_q : gmin_b;
			gmax_q <= ($signed(gap_q) > $signed(gmax_b)) ? gap_q : gmax_b;
			smin_q <= (bytes_q < smin_b) ? bytes_q : smin_b;
			smax_q <= (bytes_q > smax_b) ? bytes_q : smax_b;
			rmin_q <= (rate_q < rmin_b) ? rate_q : rmin_b;
			rmax_q <= (rate_q > rmax_b) ? rate_q : rmax_b;
		end
	end

	// Output register: a closing packet snapshots the old window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd_go && close_q) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_go && close_q) begin
			out_q.close_time_ps    <= arr_q;
			out_q.window_length_ps <= len_q;
			out_q.pkt_tally        <= cnt_q;
			out_q.min_gap_ps       <= gmin_q;
			out_q.max_gap_ps       <= gmax_q;
			out_q.gap_sum_ps       <= gsum_q;
			out_q.min_size         <= smin_q;
			out_q.max_size         <= smax_q;
			out_q.byte_sum         <= bsum_q;
			out_q.min_rate_pps     <= rmin_q;
			out_q.max_rate_pps     <= rmax_q;
			out_q.rate_sum_pps     <= rsum_q;
		end
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.payload = out_q;

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD && close_q && out_valid_q && !out_ch.ready) |=> state_q == ST_UPD)
		else $error("closing packet left its step while the result was blocked");
	a_result_from_upd: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_UPD && close_q))
		else $error("result beat not caused by a closing packet");
	a_seen_sticky: assert property (@(posedge clk) disable iff (!arst_n) !$fell(seen_q))
		else $error("first packet flag cleared");
	a_rate_needs_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RATE) |-> !gap_q[TIME_W-1] && gap_q != '0)
		else $error("rate divide with a gap that is not positive");
endmodule

[test/wprs_stats_checker.sv]
module wprs_stats_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  wprs_pkg::cfg_idx_t          cfg_index,
	input  logic [wprs_pkg::BT_W-1:0]   cfg_wdata,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  wprs_pkg::pkt_t              in_pkt,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  wprs_pkg::stats_t            out_stats,
	output int                          fail_count,
	output int                          reports_pending
);
	import wprs_pkg::*;

	localparam longint GAP_POS_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint GAP_NEG_MAX = 64'sh8000_0000_0000_0000;
	localparam logic [63:0] RATE_TOP = 64'd1000000000000;
	localparam logic [63:0] MS_IN_PS = 64'd1000000000;

	// Shadow of the configuration registers.
	logic [15:0] win_ms;
	logic [23:0] bit_fs;

	// Shadow of the window state.
	logic        seen_first;
	logic [63:0] win_start;
	logic [63:0] last_end;
	logic [31:0] win_pos;
	logic [63:0] pkt_cnt;
	longint      gap_total;
	logic [63:0] byte_total;
	logic [63:0] rate_total;
	longint      gap_lo;
	longint      gap_hi;
	logic [15:0] size_lo;
	logic [15:0] size_hi;
	logic [63:0] rate_lo;
	logic [63:0] rate_hi;

	stats_t window_reports_q[$];
	int     mismatches;

	assign fail_count      = mismatches;
	assign reports_pending = window_reports_q.size();

	function automatic logic [63:0] cap_add(logic [63:0] a, logic [63:0] b, logic [63:0] lim);
		logic [63:0] s;
		s = a + b;
		return (s > lim) ? lim : s;
	endfunction

	function automatic longint cap_add_signed(longint a, longint b);
		longint s;
		s = a + b;
		if ((a < 0) == (b < 0) && (s < 0) != (a < 0))
			return (a < 0) ? GAP_NEG_MAX : GAP_POS_MAX;
		return s;
	endfunction

	task automatic clear_window();
		pkt_cnt    = 0;
		gap_total  = 0;
		byte_total = 0;
		rate_total = 0;
		gap_lo     = GAP_POS_MAX;
		gap_hi     = GAP_NEG_MAX;
		size_lo    = 16'hFFFF;
		size_hi    = 0;
		rate_lo    = 64'hFF_FFFF_FFFF;
		rate_hi    = 0;
	endtask

	// Advance the window state by one packet, queueing a report on close.
	task automatic track_packet(pkt_t p);
		logic [63:0] arr;
		logic [63:0] len;
		logic [63:0] ser_ns;
		logic [63:0] cur_end;
		logic [63:0] d;
		longint      gap;
		logic [63:0] rate;
		stats_t      rep;
		arr     = {1'b0, p.arrival_ps};
		len     = {48'd0, p.packet_bytes};
		ser_ns  = (len * 64'd8 * {40'd0, bit_fs}) / 64'd1000000;
		cur_end = arr + ser_ns * 64'd1000;
		if (!seen_first) begin
			seen_first = 1'b1;
			win_start  = arr;
			last_end   = cur_end;
			win_pos    = 0;
			return;
		end
		if (win_pos != 32'hFFFF_FFFF)
			win_pos++;
		if (arr >= win_start && arr - win_start > {48'd0, win_ms} * MS_IN_PS && win_pos >= 2) begin
			rep.close_time_ps    = p.arrival_ps;
			rep.window_length_ps = 63'(arr - win_start);
			rep.pkt_tally        = pkt_cnt[31:0];
			rep.min_gap_ps       = gap_lo;
			rep.max_gap_ps       = gap_hi;
			rep.gap_sum_ps       = gap_total;
			rep.min_size         = size_lo;
			rep.max_size         = size_hi;
			rep.byte_sum         = byte_total[47:0];
			rep.min_rate_pps     = rate_lo[39:0];
			rep.max_rate_pps     = rate_hi[39:0];
			rep.rate_sum_pps     = rate_total[62:0];
			window_reports_q.push_back(rep);
			clear_window();
			win_start = arr;
			win_pos   = 0;
		end
		// End to end gap, saturated to the signed range.
		if (cur_end >= last_end) begin
			d   = cur_end - last_end;
			gap = d[63] ? GAP_POS_MAX : longint'(d);
		end else begin
			d   = last_end - cur_end;
			gap = d[63] ? GAP_NEG_MAX : -longint'(d);
		end
		rate = (gap <= 0) ? RATE_TOP : RATE_TOP / 64'(gap);
		pkt_cnt    = cap_add(pkt_cnt, 64'd1, 64'hFFFF_FFFF);
		gap_total  = cap_add_signed(gap_total, gap);
		byte_total = cap_add(byte_total, len, 64'hFFFF_FFFF_FFFF);
		rate_total = cap_add(rate_total, rate, 64'h7FFF_FFFF_FFFF_FFFF);
		if (gap < gap_lo) gap_lo = gap;
		if (gap > gap_hi) gap_hi = gap;
		if (p.packet_bytes < size_lo) size_lo = p.packet_bytes;
		if (p.packet_bytes > size_hi) size_hi = p.packet_bytes;
		if (rate < rate_lo) rate_lo = rate;
		if (rate > rate_hi) rate_hi = rate;
		last_end = cur_end;
	endtask

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("MISMATCH %s: expected %h, got %h", name, want, got);
		end
	endtask

	// Follow configuration writes and packet beats, then compare result beats.
	always @(posedge clk or negedge arst_n) begin
		stats_t want;
		if (!arst_n) begin
			win_ms     = 16'd100;
			bit_fs     = 24'd100000;
			seen_first = 1'b0;
			win_start  = 0;
			last_end   = 0;
			win_pos    = 0;
			clear_window();
			window_reports_q.delete();
			mismatches = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_WIN_LEN: begin
						win_ms = cfg_wdata[15:0];
					end
					CFG_BIT_TIME_FS: begin
						bit_fs = cfg_wdata;
					end
					default: begin
					end
				endcase
			end
			if (out_valid && out_ready) begin
				if (window_reports_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("MISMATCH unexpected report beat at close time %h",
							out_stats.close_time_ps);
				end else begin
					want = window_reports_q.pop_front();
					check_field("close_time_ps", 64'(want.close_time_ps),
						64'(out_stats.close_time_ps));
					check_field("window_length_ps", 64'(want.window_length_ps),
						64'(out_stats.window_length_ps));
					check_field("pkt_tally", 64'(want.pkt_tally),
						64'(out_stats.pkt_tally));
					check_field("min_gap_ps", want.min_gap_ps, out_stats.min_gap_ps);
					check_field("max_gap_ps", want.max_gap_ps, out_stats.max_gap_ps);
					check_field("gap_sum_ps", want.gap_sum_ps, out_stats.gap_sum_ps);
					check_field("min_size", 64'(want.min_size), 64'(out_stats.min_size));
					check_field("max_size", 64'(want.max_size), 64'(out_stats.max_size));
					check_field("byte_sum", 64'(want.byte_sum), 64'(out_stats.byte_sum));
					check_field("min_rate_pps", 64'(want.min_rate_pps),
						64'(out_stats.min_rate_pps));
					check_field("max_rate_pps", 64'(want.max_rate_pps),
						64'(out_stats.max_rate_pps));
					check_field("rate_sum_pps", 64'(want.rate_sum_pps),
						64'(out_stats.rate_sum_pps));
				end
			end
			if (in_valid && in_ready)
				track_packet(in_pkt);
		end
	end
endmodule

[test/windowed_packet_rate_stats_tb.sv]
module windowed_packet_rate_stats_tb;
	import wprs_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam logic [62:0] ARRIVAL_TOP = 63'h7FFF_FFFF_FFFF_FFFF;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	cfg_idx_t           cfg_index = CFG_WIN_LEN;
	logic [BT_W-1:0]    cfg_wdata = '0;
	int                 fail_count;
	int                 reports_pending;
	int                 cycles = 0;
	int                 burst_left = 0;
	logic [62:0]        now_ps = '0;
	logic [63:0]        window_ps = 64'd100000000000;

	wprs_stream_if #(.T(pkt_t))   in_ch ();
	wprs_stream_if #(.T(stats_t)) out_ch ();

	windowed_packet_rate_stats i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	wprs_stats_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_ch.valid),
		.in_ready        (in_ch.ready),
		.in_pkt          (in_ch.payload),
		.out_valid       (out_ch.valid),
		.out_ready       (out_ch.ready),
		.out_stats       (out_ch.payload),
		.fail_count      (fail_count),
		.reports_pending (reports_pending)
	);

	always #5 clk = ~clk;

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// The report receiver switches between randomly chosen stall patterns.
	initial begin
		int mode;
		out_ch.ready = 1'b0;
		forever begin
			mode = $urandom_range(0, 2);
			repeat (64) begin
				@(negedge clk);
				case (mode)
					0: out_ch.ready <= 1'b1;
					1: out_ch.ready <= ($urandom_range(0, 1) == 1);
					default: out_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Offer one packet beat and wait for its acceptance; bursts end with a gap.
	task automatic send_packet(logic [62:0] arr, logic [15:0] len);
		in_ch.valid   <= 1'b1;
		in_ch.payload <= '{arrival_ps: arr, packet_bytes: len};
		do
			@(posedge clk);
		while (!in_ch.ready);
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_ch.valid <= 1'b0;
			burst_left = $urandom_range(0, 8);
			repeat ($urandom_range(1, 40)) @(negedge clk);
		end
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [BT_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		@(negedge clk);
	endtask

	// Hold the sender until every report is in and the last packet has settled.
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (reports_pending != 0)
			@(negedge clk);
		repeat (150) @(negedge clk);
	endtask

	task automatic set_config(logic [15:0] win, logic [23:0] bit_fs);
		drain();
		write_reg(CFG_WIN_LEN, BT_W'(win));
		write_reg(CFG_BIT_TIME_FS, bit_fs);
		window_ps = 64'(win) * 64'd1000000000;
	endtask

	// Mostly forward-moving arrivals that close a window every dozen packets or so.
	task automatic random_packets(int count);
		logic [63:0] next;
		logic [15:0] len;
		int          pick;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			len  = ($urandom_range(0, 2) == 0) ? 16'($urandom)
				: 16'($urandom_range(64, 1518));
			if (pick < 85) begin
				next = {1'b0, now_ps} + ({$urandom, $urandom} % (window_ps / 8 + 1));
			end else if (pick < 93) begin
				next = {1'b0, now_ps} - 64'($urandom_range(0, 100000));
			end else if (pick < 97) begin
				next = {1'b0, now_ps} + window_ps * 2 + 64'($urandom);
			end else begin
				next = ({$urandom, $urandom} % ({1'b0, now_ps} + 1));
			end
			if (next[63])
				next = {1'b0, now_ps};
			now_ps = (next[62:0] > now_ps) ? next[62:0] : now_ps;
			send_packet(next[62:0], len);
		end
	endtask

	initial begin
		in_ch.valid   = 1'b0;
		in_ch.payload = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed packets under the reset configuration of 100 ms at 10 Gb/s.
		send_packet(63'd0, 16'd0);
		send_packet(63'd5000, 16'hFFFF);
		send_packet(63'd5000, 16'd64);
		send_packet(63'd1000, 16'd1);
		send_packet(63'd200000000000, 16'd1500);
		send_packet(63'd200000000001, 16'd100);
		send_packet(63'd500000000000, 16'd200);
		send_packet(ARRIVAL_TOP, 16'hFFFF);
		send_packet(63'd0, 16'd0);
		send_packet(63'd700000000000, 16'h5555);
		send_packet(63'd700000000000, 16'hAAAA);
		send_packet(63'd800000000001, 16'd60);
		send_packet(63'd900000000002, 16'd60);
		now_ps = 63'd900000000002;
		random_packets(150);

		// A long bit time with the longest window, then the fastest line and shortest window.
		set_config(16'hFFFF, 24'd10000000);
		random_packets(230);
		set_config(16'd1, 24'd1);
		random_packets(230);
		set_config(16'd2, 24'd800);
		random_packets(230);
		set_config(16'd1, 24'hFFFFFF);
		random_packets(150);
		set_config(16'd100, 24'd100000);
		random_packets(150);

		drain();
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule

[windowed_packet_rate_stats.f]
hdl/wprs_pkg.sv
hdl/wprs_stream_if.sv
hdl/wprs_sdiv.sv
hdl/windowed_packet_rate_stats.sv
test/wprs_stats_checker.sv
test/windowed_packet_rate_stats_tb.sv
